// ===== hw/rtl/tbhc_pkg.sv =====
// Shared types and constants for the translation block hash cache.
// No dependencies; used by the top level and its port checker.
package tbhc_pkg;

  localparam int KIND_W   = 2;
  localparam int PC_W     = 64;
  localparam int LEN_W    = 16;
  localparam int ADDR_W   = 24;
  localparam int NEED_W   = 17;
  localparam int EPOCH_W  = 8;
  localparam int S_DATA_W = 104;
  localparam int M_DATA_W = 96;

  localparam logic [EPOCH_W-1:0] EPOCH_FIRST = EPOCH_W'(1);
  localparam logic [EPOCH_W-1:0] EPOCH_LAST  = {EPOCH_W{1'b1}};

  localparam logic [ADDR_W-1:0] AREA_RESET = 24'd1048576;

  // Output tdata bit positions
  localparam int O_HIT    = 0;
  localparam int O_OFF_LO = 1;
  localparam int O_GPC_LO = 25;
  localparam int O_CLEAN  = 89;
  localparam int O_STATUS = 90;

  typedef enum logic [1:0] {
    KIND_LOOKUP = 2'd0,
    KIND_APPEND = 2'd1,
    KIND_HOST   = 2'd2,
    KIND_CLEAN  = 2'd3
  } kind_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CLEAR,
    ST_AISS,
    ST_ABKT,
    ST_LBKT,
    ST_LREC,
    ST_WALK,
    ST_HRD,
    ST_HCHK,
    ST_FIN
  } state_t;

endpackage

// ===== hw/rtl/translation_block_hash_cache.sv =====
// Translation block hash cache: bucket and entry memories with a sequencer.
// Depends on tbhc_pkg.
//
// Code cache index for a binary translator. Each transfer on the s_ side is
// one request (lookup, append, host-to-guest lookup or clean request) and
// gives exactly one result transfer on the m_ side. Requests are served one
// at a time; a finished result waits in the output register while the next
// request is taken. A lookup that hits the bucket's most recent entry reads
// the bucket word and then that entry; a chain walk reads further entries one
// at a time through the single read port of the entry memory. An append
// writes its entry and its bucket together. A host-to-guest lookup scans
// written entries oldest first, reading and then checking each one. Buckets
// carry an epoch tag, so a flush costs nothing; after reset, and each time
// the 8-bit epoch wraps, a clearing pass writes every bucket once, during
// which no request is taken. Configuration writes are taken at any time;
// write the area only while no request is in flight.
module translation_block_hash_cache #(
  parameter int HASH_BITS    = 14,
  parameter int MAX_ENTRIES  = 4096,
  parameter int HEADER_BYTES = 18
) (
  input  logic                           clk,
  input  logic                           rst,
  // s_tdata: pc [63:0], length [79:64], host_address [103:80]
  input  logic                           s_tvalid,
  output logic                           s_tready,
  input  logic [tbhc_pkg::S_DATA_W-1:0]  s_tdata,
  // s_tuser: kind [1:0]
  input  logic [tbhc_pkg::KIND_W-1:0]    s_tuser,
  // m_tdata: hit [0], host_offset [24:1], gpc [88:25],
  //          clean_event [89], status [90], zero [95:91]
  output logic                           m_tvalid,
  input  logic                           m_tready,
  output logic [tbhc_pkg::M_DATA_W-1:0]  m_tdata,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [tbhc_pkg::ADDR_W-1:0]    cfg_data
);

  localparam int PW      = $clog2(MAX_ENTRIES + 1);
  localparam int EW      = $clog2(MAX_ENTRIES);
  localparam int NBUCKET = 1 << HASH_BITS;
  localparam int AW      = tbhc_pkg::ADDR_W;

  typedef struct packed {
    logic [tbhc_pkg::EPOCH_W-1:0] tag;
    logic [PW-1:0]                head;
    logic [PW-1:0]                recent;
  } bucket_t;

  typedef struct packed {
    logic [tbhc_pkg::PC_W-1:0]   pc;
    logic [PW-1:0]               link;
    logic [AW-1:0]               start;
    logic [tbhc_pkg::NEED_W-1:0] bytes;
  } entry_t;

  // Memories
  bucket_t bkt_mem [NBUCKET];
  entry_t  ent_mem [MAX_ENTRIES];

  bucket_t             bkt_rdata, bkt_wdata;
  logic [HASH_BITS-1:0] bkt_raddr, bkt_waddr;
  logic                bkt_we;
  entry_t              ent_rdata, ent_wdata;
  logic [EW-1:0]       ent_raddr;
  logic                ent_we;

  // Control and request registers
  tbhc_pkg::state_t state, state_next, clr_ret, clr_ret_next;
  logic [HASH_BITS-1:0]          clr_idx, clr_idx_next;
  logic [tbhc_pkg::EPOCH_W-1:0]  epoch, epoch_next;
  logic [AW-1:0]                 area, wp, wp_next;
  logic [PW-1:0]                 count, count_next;
  logic                          flush_pending, flush_pending_next;
  logic [tbhc_pkg::PC_W-1:0]     pc_reg, pc_reg_next;
  logic [tbhc_pkg::LEN_W-1:0]    len_reg, len_reg_next;
  logic [AW-1:0]                 haddr, haddr_next;
  logic [PW-1:0]                 head, head_next, cur, cur_next;
  logic [EW-1:0]                 idx, idx_next;
  logic                          res_hit, res_hit_next, res_clean, res_clean_next;
  logic                          res_status, res_status_next;
  logic [AW-1:0]                 res_off, res_off_next;
  logic [tbhc_pkg::PC_W-1:0]     res_gpc, res_gpc_next;

  // Shared decisions
  logic                          in_acc;
  tbhc_pkg::kind_t               in_kind;
  logic [tbhc_pkg::NEED_W-1:0]   in_need, need;
  logic                          in_ovf, in_big, in_wrap;
  logic [PW-1:0]                 bkt_head_v, bkt_rec_v;
  logic                          rec_ok, head_ok, bhead_ok, link_ok, ent_match;
  logic                          host_cover, scan_more, out_free;
  logic [AW-1:0]                 ent_off;

  always_ff @(posedge clk) begin
    if (bkt_we) bkt_mem[bkt_waddr] <= bkt_wdata;
    bkt_rdata <= bkt_mem[bkt_raddr];
  end

  always_ff @(posedge clk) begin
    if (ent_we) ent_mem[count[EW-1:0]] <= ent_wdata;
    ent_rdata <= ent_mem[ent_raddr];
  end

  assign cfg_ready = 1'b1;
  assign s_tready  = (state == tbhc_pkg::ST_IDLE);
  assign in_acc    = s_tvalid && s_tready;
  assign in_kind   = tbhc_pkg::kind_t'(s_tuser);
  assign in_need   = tbhc_pkg::NEED_W'(s_tdata[79:64]) + tbhc_pkg::NEED_W'(HEADER_BYTES);
  assign need      = tbhc_pkg::NEED_W'(len_reg) + tbhc_pkg::NEED_W'(HEADER_BYTES);
  assign in_ovf    = ((AW + 1)'(wp) + (AW + 1)'(in_need) > (AW + 1)'(area))
                     || (count == PW'(MAX_ENTRIES));
  assign in_big    = (AW'(in_need) > area);
  assign in_wrap   = (epoch == tbhc_pkg::EPOCH_LAST);

  // Bucket words with a stale tag read as empty
  assign bkt_head_v = (bkt_rdata.tag == epoch) ? bkt_rdata.head   : '0;
  assign bkt_rec_v  = (bkt_rdata.tag == epoch) ? bkt_rdata.recent : '0;
  assign rec_ok     = (bkt_rec_v != '0) && (bkt_rec_v <= count);
  assign bhead_ok   = (bkt_head_v != '0) && (bkt_head_v <= count);
  assign head_ok    = (head != '0) && (head <= count);
  assign link_ok    = (ent_rdata.link != '0) && (ent_rdata.link <= count);
  assign ent_match  = (ent_rdata.pc == pc_reg);
  assign ent_off    = ent_rdata.start + AW'(HEADER_BYTES);
  assign host_cover = (haddr >= ent_rdata.start) &&
                      ((AW + 1)'(haddr) < (AW + 1)'(ent_rdata.start)
                                          + (AW + 1)'(ent_rdata.bytes));
  assign scan_more  = (PW'(idx) + PW'(1)) < count;
  assign out_free   = !m_tvalid || m_tready;

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      tbhc_pkg::ST_IDLE: begin
        if (in_acc) begin
          unique case (in_kind)
            tbhc_pkg::KIND_LOOKUP: begin
              if (flush_pending) state_next = in_wrap ? tbhc_pkg::ST_CLEAR : tbhc_pkg::ST_FIN;
              else state_next = tbhc_pkg::ST_LBKT;
            end
            tbhc_pkg::KIND_APPEND: begin
              if (in_ovf && in_wrap) state_next = tbhc_pkg::ST_CLEAR;
              else if (in_big) state_next = tbhc_pkg::ST_FIN;
              else state_next = tbhc_pkg::ST_ABKT;
            end
            tbhc_pkg::KIND_HOST: begin
              state_next = (count == '0) ? tbhc_pkg::ST_FIN : tbhc_pkg::ST_HRD;
            end
            default: state_next = tbhc_pkg::ST_FIN;
          endcase
        end
      end
      tbhc_pkg::ST_CLEAR: begin
        if (clr_idx == HASH_BITS'(NBUCKET - 1)) state_next = clr_ret;
      end
      tbhc_pkg::ST_AISS: state_next = tbhc_pkg::ST_ABKT;
      tbhc_pkg::ST_ABKT: state_next = tbhc_pkg::ST_FIN;
      tbhc_pkg::ST_LBKT: begin
        if (rec_ok) state_next = tbhc_pkg::ST_LREC;
        else if (bhead_ok) state_next = tbhc_pkg::ST_WALK;
        else state_next = tbhc_pkg::ST_FIN;
      end
      tbhc_pkg::ST_LREC: begin
        if (!ent_match && head_ok) state_next = tbhc_pkg::ST_WALK;
        else state_next = tbhc_pkg::ST_FIN;
      end
      tbhc_pkg::ST_WALK: begin
        if (ent_match || !link_ok) state_next = tbhc_pkg::ST_FIN;
      end
      tbhc_pkg::ST_HRD: state_next = tbhc_pkg::ST_HCHK;
      tbhc_pkg::ST_HCHK: begin
        if (!host_cover && scan_more) state_next = tbhc_pkg::ST_HRD;
        else state_next = tbhc_pkg::ST_FIN;
      end
      tbhc_pkg::ST_FIN: begin
        if (out_free) state_next = tbhc_pkg::ST_IDLE;
      end
      default: state_next = tbhc_pkg::ST_IDLE;
    endcase
  end

  // Datapath and memory controls
  always_comb begin
    clr_ret_next       = clr_ret;
    clr_idx_next       = clr_idx;
    epoch_next         = epoch;
    wp_next            = wp;
    count_next         = count;
    flush_pending_next = flush_pending;
    pc_reg_next        = pc_reg;
    len_reg_next       = len_reg;
    haddr_next         = haddr;
    head_next          = head;
    cur_next           = cur;
    idx_next           = idx;
    res_hit_next       = res_hit;
    res_off_next       = res_off;
    res_gpc_next       = res_gpc;
    res_clean_next     = res_clean;
    res_status_next    = res_status;

    bkt_raddr = pc_reg[HASH_BITS+1:2];
    bkt_waddr = pc_reg[HASH_BITS+1:2];
    bkt_we    = 1'b0;
    bkt_wdata = '{tag: epoch, head: head, recent: cur};
    ent_raddr = idx;
    ent_we    = 1'b0;
    ent_wdata = '{pc: pc_reg, link: bkt_head_v, start: wp, bytes: need};

    unique case (state)
      tbhc_pkg::ST_IDLE: begin
        bkt_raddr = s_tdata[HASH_BITS+1:2];
        if (in_acc) begin
          pc_reg_next     = s_tdata[63:0];
          len_reg_next    = s_tdata[79:64];
          haddr_next      = s_tdata[103:80];
          idx_next        = '0;
          res_hit_next    = 1'b0;
          res_off_next    = '0;
          res_gpc_next    = '0;
          res_clean_next  = 1'b0;
          res_status_next = 1'b0;
          unique case (in_kind)
            tbhc_pkg::KIND_LOOKUP: begin
              if (flush_pending) begin
                flush_pending_next = 1'b0;
                res_clean_next     = 1'b1;
                wp_next            = '0;
                count_next         = '0;
                epoch_next         = in_wrap ? tbhc_pkg::EPOCH_FIRST : epoch + 1'b1;
                clr_ret_next       = tbhc_pkg::ST_FIN;
                clr_idx_next       = '0;
              end
            end
            tbhc_pkg::KIND_APPEND: begin
              if (in_ovf) begin
                res_clean_next = 1'b1;
                wp_next        = '0;
                count_next     = '0;
                epoch_next     = in_wrap ? tbhc_pkg::EPOCH_FIRST : epoch + 1'b1;
                clr_idx_next   = '0;
              end
              res_status_next = in_big;
              clr_ret_next    = in_big ? tbhc_pkg::ST_FIN : tbhc_pkg::ST_AISS;
            end
            tbhc_pkg::KIND_HOST: ;
            default: flush_pending_next = 1'b1;
          endcase
        end
      end
      tbhc_pkg::ST_CLEAR: begin
        bkt_we       = 1'b1;
        bkt_waddr    = clr_idx;
        bkt_wdata    = '0;
        clr_idx_next = clr_idx + 1'b1;
      end
      tbhc_pkg::ST_AISS: ;
      tbhc_pkg::ST_ABKT: begin
        ent_we       = 1'b1;
        bkt_we       = 1'b1;
        bkt_wdata    = '{tag: epoch, head: count + 1'b1, recent: bkt_rec_v};
        count_next   = count + 1'b1;
        wp_next      = wp + AW'(need);
        res_off_next = wp + AW'(HEADER_BYTES);
      end
      tbhc_pkg::ST_LBKT: begin
        head_next = bkt_head_v;
        cur_next  = bkt_head_v;
        ent_raddr = rec_ok ? EW'(bkt_rec_v - 1'b1) : EW'(bkt_head_v - 1'b1);
      end
      tbhc_pkg::ST_LREC: begin
        ent_raddr = EW'(head - 1'b1);
        if (ent_match) begin
          res_hit_next = 1'b1;
          res_off_next = ent_off;
        end
      end
      tbhc_pkg::ST_WALK: begin
        ent_raddr = EW'(ent_rdata.link - 1'b1);
        if (ent_match) begin
          // record the hit as the bucket's most recent
          bkt_we       = 1'b1;
          res_hit_next = 1'b1;
          res_off_next = ent_off;
        end else begin
          cur_next = ent_rdata.link;
        end
      end
      tbhc_pkg::ST_HRD: ent_raddr = idx;
      tbhc_pkg::ST_HCHK: begin
        if (host_cover) begin
          res_hit_next = 1'b1;
          res_gpc_next = ent_rdata.pc;
          res_off_next = ent_off;
        end else begin
          idx_next = idx + 1'b1;
        end
      end
      tbhc_pkg::ST_FIN: ;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= tbhc_pkg::ST_CLEAR;
      clr_ret       <= tbhc_pkg::ST_IDLE;
      clr_idx       <= '0;
      epoch         <= tbhc_pkg::EPOCH_FIRST;
      wp            <= '0;
      count         <= '0;
      flush_pending <= 1'b0;
      area          <= tbhc_pkg::AREA_RESET;
      m_tvalid      <= 1'b0;
    end else begin
      state         <= state_next;
      // the state to return to after a clear sweep is held while the sweep runs
      clr_ret       <= (state == tbhc_pkg::ST_IDLE) ? clr_ret_next :
                       (state == tbhc_pkg::ST_CLEAR) ? clr_ret : clr_ret_next;
      clr_idx       <= clr_idx_next;
      epoch         <= epoch_next;
      wp            <= wp_next;
      count         <= count_next;
      flush_pending <= flush_pending_next;
      if (cfg_valid && cfg_ready) area <= cfg_data;
      if (state == tbhc_pkg::ST_FIN && out_free) m_tvalid <= 1'b1;
      else if (m_tready) m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    pc_reg     <= pc_reg_next;
    len_reg    <= len_reg_next;
    haddr      <= haddr_next;
    head       <= head_next;
    cur        <= cur_next;
    idx        <= idx_next;
    res_hit    <= res_hit_next;
    res_off    <= res_off_next;
    res_gpc    <= res_gpc_next;
    res_clean  <= res_clean_next;
    res_status <= res_status_next;
    if (state == tbhc_pkg::ST_FIN && out_free) begin
      m_tdata <= {5'b0, res_status, res_clean, res_gpc, res_off, res_hit};
    end
  end

endmodule

// ===== hw/rtl/tbhc_checker.sv =====
// Port-level checks for the translation block hash cache, bound to the top.
// Depends on tbhc_pkg and translation_block_hash_cache.
module tbhc_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          s_tvalid,
  input logic                          s_tready,
  input logic                          m_tvalid,
  input logic                          m_tready,
  input logic [tbhc_pkg::M_DATA_W-1:0] m_tdata
);

  // Held result stays put until taken
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result changed while stalled");

  // One request at a time
  a_one: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("second request taken while busy");

  // Oversize append always flushes and never hits
  a_big: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[tbhc_pkg::O_STATUS] |->
      m_tdata[tbhc_pkg::O_CLEAN] && !m_tdata[tbhc_pkg::O_HIT])
    else $error("status without flush");

  // A guest pc is only reported with a hit
  a_gpc: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tdata[tbhc_pkg::O_GPC_LO +: tbhc_pkg::PC_W] != '0) |->
      m_tdata[tbhc_pkg::O_HIT])
    else $error("guest pc without hit");

endmodule

bind translation_block_hash_cache tbhc_checker u_tbhc_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

// ===== bench/translation_block_hash_cache_tb.sv =====
// Self-checking bench for translation_block_hash_cache: directed table, then random phases.
// Needs tbhc_pkg and the block; the expected results come from an in-bench cache predictor.
module translation_block_hash_cache_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NBUCKET  = 1 << 14;
  localparam int NENTRY   = 4096;
  localparam int HDR      = 18;
  localparam int LIMIT    = 4000000;
  localparam logic [63:0] PC_MAX = 64'hFFFF_FFFF_FFFF_FFFF;

  typedef struct {
    tbhc_pkg::kind_t kind;
    logic [63:0]     pc;
    logic [15:0]     len;
    logic [23:0]     addr;
  } request_t;

  // directed row: request plus an optional typed-in answer
  typedef struct {
    request_t    req;
    bit          typed;
    logic [95:0] answer;
  } row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  // pc [63:0], length [79:64], host_address [103:80]
  logic [tbhc_pkg::S_DATA_W-1:0] s_tdata = '0;
  logic [tbhc_pkg::KIND_W-1:0] s_tuser = '0;    // kind [1:0]
  logic m_tvalid;
  logic m_tready = 1'b0;
  // hit [0], host_offset [24:1], gpc [88:25], clean_event [89], status [90], zero [95:91]
  logic [tbhc_pkg::M_DATA_W-1:0] m_tdata;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [tbhc_pkg::ADDR_W-1:0] cfg_data = '0;

  translation_block_hash_cache dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Cache predictor. Bucket slots hold entry index + 1, absent key means empty,
  // so a flush deletes both bucket maps and resets write position and entry count.
  // ---------------------------------------------------------------------------
  int          bkt_head[int];
  int          bkt_recent[int];
  logic [63:0] ent_pc[NENTRY];
  int          ent_link[NENTRY];
  int          ent_start[NENTRY];
  int          ent_bytes[NENTRY];
  int          wr_pos = 0;
  int          n_entries = 0;
  bit          clean_req = 1'b0;
  int          area = int'(tbhc_pkg::AREA_RESET);

  logic [95:0] awaited_results[$];
  int          errors = 0;
  int          cycles = 0;
  bit          long_hold = 1'b0;
  logic [63:0] pc_pool[64];

  function automatic void wipe_cache();
    bkt_head.delete();
    bkt_recent.delete();
    wr_pos = 0;
    n_entries = 0;
  endfunction

  function automatic logic [95:0] cache_outcome(request_t r);
    logic        hit, clean, status;
    logic [23:0] off;
    logic [63:0] gpc;
    int          b, cur, e, need, steps;
    hit = 0; clean = 0; status = 0; off = '0; gpc = '0;
    b = int'(r.pc[15:2]);
    case (r.kind)
      tbhc_pkg::KIND_LOOKUP: begin
        if (clean_req) begin
          wipe_cache();
          clean_req = 1'b0;
          clean = 1;
        end else begin
          cur = bkt_recent.exists(b) ? bkt_recent[b] : 0;
          if (cur != 0 && cur <= n_entries && ent_pc[cur-1] == r.pc) begin
            hit = 1;
            off = 24'(ent_start[cur-1] + HDR);
          end else begin
            cur = bkt_head.exists(b) ? bkt_head[b] : 0;
            steps = 0;
            while (cur != 0 && cur <= n_entries && steps < NENTRY && !hit) begin
              if (ent_pc[cur-1] == r.pc) begin
                bkt_recent[b] = cur;
                hit = 1;
                off = 24'(ent_start[cur-1] + HDR);
              end else begin
                cur = ent_link[cur-1];
                steps++;
              end
            end
          end
        end
      end
      tbhc_pkg::KIND_APPEND: begin
        need = int'(r.len) + HDR;
        if (wr_pos + need > area || n_entries >= NENTRY) begin
          wipe_cache();
          clean = 1;
        end
        if (need > area) begin
          status = 1;
        end else begin
          e = n_entries;
          ent_pc[e] = r.pc;
          ent_start[e] = wr_pos;
          ent_bytes[e] = need;
          ent_link[e] = bkt_head.exists(b) ? bkt_head[b] : 0;
          bkt_head[b] = e + 1;
          n_entries = e + 1;
          off = 24'(wr_pos + HDR);
          wr_pos += need;
        end
      end
      tbhc_pkg::KIND_HOST: begin
        for (e = 0; e < n_entries && !hit; e++) begin
          if (int'(r.addr) >= ent_start[e] &&
              int'(r.addr) < ent_start[e] + ent_bytes[e]) begin
            hit = 1;
            gpc = ent_pc[e];
            off = 24'(ent_start[e] + HDR);
          end
        end
      end
      default: clean_req = 1'b1;
    endcase
    return {5'b0, status, clean, gpc, off, hit};
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  function automatic request_t make_req(tbhc_pkg::kind_t k, logic [63:0] pc, int len,
                                        int addr);
    request_t r;
    r.kind = k;
    r.pc = pc;
    r.len = 16'(len);
    r.addr = 24'(addr);
    return r;
  endfunction

  function automatic logic [63:0] rand_pc();
    logic [63:0] p;
    p = {$urandom, $urandom};
    // mostly reuse the pool so lookups hit and chains grow
    return ($urandom_range(0, 9) == 0) ? p : pc_pool[$urandom_range(0, 63)];
  endfunction

  function automatic request_t rand_req();
    request_t r;
    int       pick, len;
    pick = $urandom_range(0, 99);
    len = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 65517)
                                      : $urandom_range(0, 300);
    r.pc = rand_pc();
    r.len = 16'(len);
    r.addr = ($urandom_range(0, 3) == 0) ? 24'($urandom)
                                         : 24'($urandom_range(0, wr_pos + 40));
    if (pick < 40) r.kind = tbhc_pkg::KIND_LOOKUP;
    else if (pick < 80) r.kind = tbhc_pkg::KIND_APPEND;
    else if (pick < 95) r.kind = tbhc_pkg::KIND_HOST;
    else r.kind = tbhc_pkg::KIND_CLEAN;
    return r;
  endfunction

  // Present one request from a falling edge, hold it until the transfer,
  // then advance to the next falling edge. Valid is left high for the caller.
  task automatic offer(request_t r, bit typed, logic [95:0] answer);
    logic [95:0] predicted;
    s_tvalid <= 1'b1;
    s_tdata <= {r.addr, r.len, r.pc};
    s_tuser <= r.kind;
    do @(posedge clk); while (!s_tready);
    predicted = cache_outcome(r);
    awaited_results.push_back(typed ? answer : predicted);
    @(negedge clk);
  endtask

  int burst_left = 0;

  task automatic offer_bursty(request_t r);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 20);
      if ($urandom_range(0, 2) != 0) begin
        s_tvalid <= 1'b0;
        repeat ($urandom_range(1, 8)) @(negedge clk);
      end
    end
    burst_left--;
    offer(r, 1'b0, '0);
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    while (awaited_results.size() != 0) @(negedge clk);
  endtask

  task automatic set_area(int value);
    cfg_valid <= 1'b1;
    cfg_data <= 24'(value);
    do @(posedge clk); while (!cfg_ready);
    area = value & 24'hFFFFFF;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Receiver: stalls on its own pattern; one long hold-off on request.
  // ---------------------------------------------------------------------------
  initial begin
    int stretch, busy_pct, n;
    forever begin
      if (long_hold) begin
        m_tready <= 1'b0;
        for (n = 0; n < 300; n++) @(negedge clk);
        long_hold = 1'b0;
      end else begin
        stretch = $urandom_range(5, 60);
        busy_pct = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(10, 80);
        for (n = 0; n < stretch && !long_hold; n++) begin
          @(negedge clk);
          m_tready <= ($urandom_range(1, 100) > busy_pct);
        end
      end
    end
  end

  // Compare every result transfer with the oldest expectation.
  always @(posedge clk) begin
    logic [95:0] want;
    if (!rst && m_tvalid && m_tready) begin
      if (awaited_results.size() == 0) begin
        $display("%0t: unexpected result %h", $realtime, m_tdata);
        errors++;
      end else begin
        want = awaited_results.pop_front();
        if (m_tdata !== want) begin
          $display("%0t: mismatch hit exp %0d got %0d, offset exp %h got %h",
                   $realtime, want[0], m_tdata[0], want[24:1], m_tdata[24:1]);
          $display("%0t:   gpc exp %h got %h, clean exp %0d got %0d",
                   $realtime, want[88:25], m_tdata[88:25], want[89], m_tdata[89]);
          $display("%0t:   status exp %0d got %0d, pad exp %h got %h",
                   $realtime, want[90], m_tdata[90], want[95:91], m_tdata[95:91]);
          errors++;
        end
      end
    end
  end

  // Watchdog on total cycles.
  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Directed table, walked under the reset area size.
  // ---------------------------------------------------------------------------
  row_t table_rows[$];

  function automatic row_t row(request_t r, bit typed, logic [95:0] answer);
    row_t t;
    t.req = r;
    t.typed = typed;
    t.answer = answer;
    return t;
  endfunction

  // pack an answer: hit, offset, guest pc, clean, status
  function automatic logic [95:0] ans(bit h, int off, logic [63:0] g, bit c, bit s);
    return {5'b0, s, c, g, 24'(off), h};
  endfunction

  initial begin
    int areas[$];
    int p, i, n;
    request_t r;

    for (i = 0; i < 64; i++)
      pc_pool[i] = ({$urandom, $urandom} & ~64'hFFFF) | 64'((i % 8) << 2)
                   | 64'($urandom_range(0, 3));

    // empty cache misses; clean then lookup flushes; extremes of pc and length
    table_rows.push_back(row(make_req(tbhc_pkg::KIND_LOOKUP, 64'h0, 0, 0),
                             1, ans(0, 0, 0, 0, 0)));
    table_rows.push_back(row(make_req(tbhc_pkg::KIND_HOST, PC_MAX, 65517, 24'hFFFFFF),
                             1, ans(0, 0, 0, 0, 0)));
    table_rows.push_back(row(make_req(tbhc_pkg::KIND_CLEAN, 64'h0, 0, 0),
                             1, ans(0, 0, 0, 0, 0)));
    table_rows.push_back(row(make_req(tbhc_pkg::KIND_APPEND, 64'h40, 5, 0),
                             1, ans(0, 18, 0, 0, 0)));
    // host lookup ignores the pending flush
    table_rows.push_back(row(make_req(tbhc_pkg::KIND_HOST, 0, 0, 3),
                             1, ans(1, 18, 64'h40, 0, 0)));
    table_rows.push_back(row(make_req(tbhc_pkg::KIND_LOOKUP, 64'h40, 0, 0),
                             1, ans(0, 0, 0, 1, 0)));
    table_rows.push_back(row(make_req(tbhc_pkg::KIND_APPEND, PC_MAX, 0, 0),
                             1, ans(0, 18, 0, 0, 0)));
    table_rows.push_back(row(make_req(tbhc_pkg::KIND_LOOKUP, PC_MAX, 0, 0),
                             1, ans(1, 18, 0, 0, 0)));
    table_rows.push_back(row(make_req(tbhc_pkg::KIND_HOST, 0, 0, 0),
                             1, ans(1, 18, PC_MAX, 0, 0)));
    table_rows.push_back(row(make_req(tbhc_pkg::KIND_HOST, 0, 0, 18),
                             1, ans(0, 0, 0, 0, 0)));
    // three entries in bucket 0 to force a chain walk
    table_rows.push_back(row(make_req(tbhc_pkg::KIND_APPEND, 64'h10000, 100, 0),
                             1, ans(0, 36, 0, 0, 0)));
    table_rows.push_back(row(make_req(tbhc_pkg::KIND_APPEND, 64'h0, 65517, 0),
                             1, ans(0, 154, 0, 0, 0)));
    table_rows.push_back(row(make_req(tbhc_pkg::KIND_APPEND, 64'h20000, 7, 0), 0, '0));
    table_rows.push_back(row(make_req(tbhc_pkg::KIND_LOOKUP, 64'h10000, 0, 0), 0, '0));
    table_rows.push_back(row(make_req(tbhc_pkg::KIND_LOOKUP, 64'h10000, 0, 0), 0, '0));
    table_rows.push_back(row(make_req(tbhc_pkg::KIND_LOOKUP, 64'h0, 0, 0), 0, '0));
    table_rows.push_back(row(make_req(tbhc_pkg::KIND_LOOKUP, 64'h30000, 0, 0), 0, '0));
    table_rows.push_back(row(make_req(tbhc_pkg::KIND_HOST, 0, 0, 65670), 0, '0));
    table_rows.push_back(row(make_req(tbhc_pkg::KIND_HOST, 0, 0, 65671), 0, '0));
    table_rows.push_back(row(make_req(tbhc_pkg::KIND_APPEND, 64'h5555, 65517, 0), 0, '0));

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (table_rows[i]) offer(table_rows[i].req, table_rows[i].typed, table_rows[i].answer);
    drain();

    // Area settings: extremes first (zero refuses every append, 17/18 sit on the
    // header size), then mid sizes; small areas keep chains and scans short.
    areas = '{0, 17, 18, 19, 24'hFFFFFF, 65535, 400, 2000, 150, 5000, 800, 300, 60};
    foreach (areas[p]) begin
      set_area(areas[p]);
      n = (areas[p] == 24'hFFFFFF) ? 60 : 125;
      for (i = 0; i < n; i++) begin
        r = rand_req();
        offer_bursty(r);
        // hold off the receiver so the block backs up onto its input
        if (p == 7 && i == 20) long_hold = 1'b1;
        // pause the sender until every result is back
        if (p == 8 && i == 50) drain();
      end
      drain();
    end

    // push the write position well past the next area size
    set_area(24'hFFFFFF);
    for (i = 0; i < 5; i++)
      offer(make_req(tbhc_pkg::KIND_APPEND, rand_pc(), 1000, 0), 1'b0, '0);
    drain();

    // shrink the area below the write position; next append must flush
    set_area(2500);
    for (i = 0; i < 120; i++) offer_bursty(rand_req());
    drain();

    repeat (60) @(posedge clk);
    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hw/rtl/tbhc_pkg.sv
hw/rtl/translation_block_hash_cache.sv
hw/rtl/tbhc_checker.sv
bench/translation_block_hash_cache_tb.sv
